### rtl/ksp_pkg.sv
`timescale 1ns / 1ps

package ksp_pkg;

    localparam int KEY_W    = 56;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 9;
    localparam int POOL_W   = 5;

    localparam int DEF_POOL_COUNT     = 32;
    localparam int DEF_SLOTS_PER_POOL = 16;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic clear_wr;
        logic start;
        logic issue;
        logic hit_take;
        logic pend_miss;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic addr_last;
        logic issue_done;
        logic hit;
        logic scan_end;
        logic out_free;
    } t_dp_stat;

endpackage

### rtl/ksp_ram.sv
`timescale 1ns / 1ps

module ksp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ksp_ctrl.sv
`timescale 1ns / 1ps

module ksp_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [ksp_pkg::OP_W-1:0]     i_opcode,
    output logic                         o_in_stall,
    input  ksp_pkg::t_dp_stat            i_stat,
    output ksp_pkg::t_ctrl_cmd           o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_NOP,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   op_valid;

    assign op_valid = (i_opcode == ksp_pkg::OP_ALLOC) || (i_opcode == ksp_pkg::OP_LOOKUP)
                   || (i_opcode == ksp_pkg::OP_FREE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.addr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = op_valid ? S_SCAN : S_NOP;
                end
            end
            S_SCAN: begin
                o_cmd.issue = !i_stat.issue_done;
                priority if (i_stat.hit) begin
                    o_cmd.hit_take = 1'b1;
                    n_state        = S_FINISH;
                end else if (i_stat.scan_end) begin
                    o_cmd.pend_miss = 1'b1;
                    n_state         = S_FINISH;
                end
            end
            S_NOP: begin
                o_cmd.pend_miss = 1'b1;
                n_state         = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### rtl/ksp_dp.sv
`timescale 1ns / 1ps

module ksp_dp #(
    parameter int POOL_COUNT     = ksp_pkg::DEF_POOL_COUNT,
    parameter int SLOTS_PER_POOL = ksp_pkg::DEF_SLOTS_PER_POOL
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [ksp_pkg::OP_W-1:0]         i_opcode,
    input  logic [ksp_pkg::KEY_W-1:0]        i_key,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [ksp_pkg::STATUS_W-1:0]     o_status,
    output logic [ksp_pkg::SLOT_W-1:0]       o_slot_index,
    output logic [ksp_pkg::POOL_W-1:0]       o_pool_number,
    input  ksp_pkg::t_ctrl_cmd               i_cmd,
    output ksp_pkg::t_dp_stat                o_stat
);

    localparam int TOTAL  = POOL_COUNT * SLOTS_PER_POOL;
    localparam int AW     = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int PW     = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int CW     = (SLOTS_PER_POOL > 1) ? $clog2(SLOTS_PER_POOL) : 1;
    localparam int KW     = ksp_pkg::KEY_W;
    localparam int DW     = KW + 1;
    localparam int OSW    = ksp_pkg::SLOT_W;
    localparam int OPW    = ksp_pkg::POOL_W;

    logic [ksp_pkg::OP_W-1:0] r_op;
    logic [KW-1:0]            r_key;
    logic [AW-1:0]            r_addr;
    logic [PW-1:0]            r_pool;
    logic [CW-1:0]            r_chunk;
    logic                     r_issue_done;
    logic                     r_q_valid;
    logic                     r_q_last;
    logic [AW-1:0]            r_q_addr;
    logic [PW-1:0]            r_q_pool;

    ksp_pkg::t_status         r_pend_status;
    logic [AW-1:0]            r_pend_slot;
    logic [PW-1:0]            r_pend_pool;

    logic                     r_out_valid;
    ksp_pkg::t_status         r_out_status;
    logic [OSW-1:0]           r_out_slot;
    logic [OPW-1:0]           r_out_pool;

    logic                     addr_last;
    logic                     advance;
    logic [DW-1:0]            rdata;
    logic                     q_busy;
    logic                     hit;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [DW-1:0]            ram_wdata;

    assign addr_last = (r_addr == AW'(TOTAL - 1));
    assign advance   = i_cmd.clear_wr || i_cmd.issue;

    // scan address with pool / chunk split kept alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_pool       <= '0;
            r_chunk      <= '0;
            r_issue_done <= 1'b0;
            r_q_valid    <= 1'b0;
        end else begin
            r_q_valid <= i_cmd.issue;
            if (i_cmd.start) begin
                r_addr       <= '0;
                r_pool       <= '0;
                r_chunk      <= '0;
                r_issue_done <= 1'b0;
            end else if (advance) begin
                r_addr <= r_addr + AW'(1);
                if (r_chunk == CW'(SLOTS_PER_POOL - 1)) begin
                    r_chunk <= '0;
                    r_pool  <= r_pool + PW'(1);
                end else begin
                    r_chunk <= r_chunk + CW'(1);
                end
                if (i_cmd.issue && addr_last) begin
                    r_issue_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_opcode;
            r_key <= i_key;
        end
        if (i_cmd.issue) begin
            r_q_addr <= r_addr;
            r_q_pool <= r_pool;
            r_q_last <= addr_last;
        end
    end

    assign q_busy = rdata[KW];
    assign hit    = r_q_valid && ((r_op == ksp_pkg::OP_ALLOC) ? !q_busy
                    : (q_busy && (rdata[KW-1:0] == r_key)));

    assign ram_we    = i_cmd.clear_wr || (i_cmd.hit_take && (r_op != ksp_pkg::OP_LOOKUP));
    assign ram_waddr = i_cmd.clear_wr ? r_addr : r_q_addr;
    assign ram_wdata = (!i_cmd.clear_wr && (r_op == ksp_pkg::OP_ALLOC)) ? {1'b1, r_key}
                                                                         : '0;

    ksp_ram #(
        .WIDTH (DW),
        .DEPTH (TOTAL)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.issue),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.hit_take) begin
            r_pend_status <= ksp_pkg::ST_OK;
            r_pend_slot   <= r_q_addr;
            r_pend_pool   <= r_q_pool;
        end else if (i_cmd.pend_miss) begin
            r_pend_status <= (r_op == ksp_pkg::OP_ALLOC) ? ksp_pkg::ST_FULL
                                                         : ksp_pkg::ST_NOT_FOUND;
            r_pend_slot   <= '0;
            r_pend_pool   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_pend_status;
            r_out_slot   <= OSW'(r_pend_slot);
            r_out_pool   <= OPW'(r_pend_pool);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot_index  = r_out_slot;
    assign o_pool_number = r_out_pool;

    assign o_stat.addr_last  = addr_last;
    assign o_stat.issue_done = r_issue_done;
    assign o_stat.hit        = hit;
    assign o_stat.scan_end   = r_q_valid && r_q_last;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

endmodule

### rtl/keyed_slot_pool_allocator.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Beat
// input     in         i_in_valid / o_in_stall   i_opcode, i_key
// result    out        o_out_valid / i_out_stall o_status, o_slot_index, o_pool_number
//
// Each beat walks the slot RAM one entry per cycle through its single read port.
// After a beat is accepted, a hit ends the scan at the first matching slot; a miss or a full
// store is reported once the last slot has been read. Unused opcode: 3 (reported as not found).
// After reset a clearing pass writes every slot of the store with input stalled.
// A new beat is taken while the previous result waits under stall.

module keyed_slot_pool_allocator #(
    parameter int POOL_COUNT     = ksp_pkg::DEF_POOL_COUNT,
    parameter int SLOTS_PER_POOL = ksp_pkg::DEF_SLOTS_PER_POOL
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [ksp_pkg::OP_W-1:0]         i_opcode,
    input  logic [ksp_pkg::KEY_W-1:0]        i_key,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [ksp_pkg::STATUS_W-1:0]     o_status,
    output logic [ksp_pkg::SLOT_W-1:0]       o_slot_index,
    output logic [ksp_pkg::POOL_W-1:0]       o_pool_number
);

    ksp_pkg::t_ctrl_cmd cmd;
    ksp_pkg::t_dp_stat  stat;

    ksp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ksp_dp #(
        .POOL_COUNT     (POOL_COUNT),
        .SLOTS_PER_POOL (SLOTS_PER_POOL)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_pool_number (o_pool_number),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

endmodule
